/* sv/paf2d_pkg.sv */
// shared types, sizes and the dominance test for the 2-d pareto archive filter
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package paf2d_pkg;

	localparam int ARCHIVE_DEPTH = 32;
	localparam int IDX_W = (ARCHIVE_DEPTH > 1) ? $clog2(ARCHIVE_DEPTH) : 1;
	localparam int CNT_W = $clog2(ARCHIVE_DEPTH + 1);
	localparam int OBJ_W = 32;
	localparam int TAG_W = 10;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [OBJ_W-1:0] first;
		logic [OBJ_W-1:0] second;
		logic [TAG_W-1:0] tag;
	} entry_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_point;
		logic rd_en;
		idx_t rd_addr;
		logic wr_en;
		logic wr_sel_point;
		idx_t wr_addr;
		logic load_out;
		logic out_last;
		logic out_ovf;
	} dp_cmd_t;

	// compare results on the entry read last cycle
	typedef struct packed {
		logic ent_dom_pt;
		logic pt_dom_ent;
	} dp_sts_t;

	// a dominates b: no worse in both objectives, strictly better in one
	function automatic logic dominates(
		input logic [OBJ_W-1:0] a1,
		input logic [OBJ_W-1:0] a2,
		input logic [OBJ_W-1:0] b1,
		input logic [OBJ_W-1:0] b2
	);
		return (a1 <= b1) && (a2 <= b2) && ((a1 < b1) || (a2 < b2));
	endfunction

endpackage

`default_nettype wire

/* sv/paf2d_pt_if.sv */
// point input channel: valid/ready plus one point per beat
// depends on paf2d_pkg
`timescale 1ns / 1ps
`default_nettype none

interface paf2d_pt_if import paf2d_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OBJ_W-1:0] obj_first;
	logic [OBJ_W-1:0] obj_second;
	logic [TAG_W-1:0] tag;
	logic             final_point;

	modport source (output valid, output obj_first, output obj_second, output tag,
		output final_point, input ready);
	modport sink (input valid, input obj_first, input obj_second, input tag,
		input final_point, output ready);
endinterface

`default_nettype wire

/* sv/paf2d_res_if.sv */
// archive dump channel: valid/ready plus one archived point per beat
// depends on paf2d_pkg
`timescale 1ns / 1ps
`default_nettype none

interface paf2d_res_if import paf2d_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OBJ_W-1:0] out_first;
	logic [OBJ_W-1:0] out_second;
	logic [TAG_W-1:0] out_tag;
	logic             overflowed;
	logic             last_entry;

	modport source (output valid, output out_first, output out_second, output out_tag,
		output overflowed, output last_entry, input ready);
	modport sink (input valid, input out_first, input out_second, input out_tag,
		input overflowed, input last_entry, output ready);
endinterface

`default_nettype wire

/* sv/paf2d_datapath.sv */
// datapath: archive memory, held point, dominance compare and dump register
// depends on paf2d_pkg; driven by paf2d_ctrl
`timescale 1ns / 1ps
`default_nettype none

module paf2d_datapath import paf2d_pkg::*; (
	input  wire logic             clk,
	input  wire dp_cmd_t          cmd,
	output dp_sts_t               sts,
	input  wire logic [OBJ_W-1:0] pt_first,
	input  wire logic [OBJ_W-1:0] pt_second,
	input  wire logic [TAG_W-1:0] pt_tag,
	output entry_t                res_entry,
	output logic                  res_ovf,
	output logic                  res_last
);

	entry_t mem [ARCHIVE_DEPTH];
	entry_t point_q;
	entry_t rd_data_q;
	entry_t out_q;
	logic   ovf_q;
	logic   last_q;
	entry_t wr_data;

	assign wr_data = cmd.wr_sel_point ? point_q : rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.load_point) begin
			point_q <= '{first: pt_first, second: pt_second, tag: pt_tag};
		end
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[cmd.rd_addr];
		end
		if (cmd.load_out) begin
			out_q  <= rd_data_q;
			ovf_q  <= cmd.out_ovf;
			last_q <= cmd.out_last;
		end
	end

	always_comb begin
		sts.ent_dom_pt = dominates(rd_data_q.first, rd_data_q.second,
			point_q.first, point_q.second);
		sts.pt_dom_ent = dominates(point_q.first, point_q.second,
			rd_data_q.first, rd_data_q.second);
	end

	assign res_entry = out_q;
	assign res_ovf   = ovf_q;
	assign res_last  = last_q;

endmodule

`default_nettype wire

/* sv/paf2d_ctrl.sv */
// controller: scan/compact pass, append, and the archive dump sequencer
// depends on paf2d_pkg; commands paf2d_datapath
`timescale 1ns / 1ps
`default_nettype none

module paf2d_ctrl import paf2d_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire logic    in_final,
	output logic         out_valid,
	input  wire logic    out_ready,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPEND,
		ST_DUMP_RD,
		ST_DUMP_LD,
		ST_DUMP_WAIT
	} state_t;

	localparam cnt_t DEPTH_C = CNT_W'(ARCHIVE_DEPTH);
	localparam cnt_t CNT_ONE = CNT_W'(1);

	state_t state_q;
	cnt_t   rd_idx_q;
	cnt_t   kept_q;
	cnt_t   count_q;
	logic   ovf_q;
	logic   dom_q;
	logic   vld_s1;
	logic   final_q;
	logic   out_valid_q;

	logic scan_rd;
	logic is_last;
	logic room;

	assign scan_rd  = (rd_idx_q < count_q);
	assign is_last  = ((rd_idx_q + CNT_ONE) == count_q);
	assign room     = (kept_q < DEPTH_C);
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load_point = in_valid;
			end
			ST_SCAN: begin
				// read ahead one entry, copy the previous one down unless it is beaten
				cmd.rd_en   = scan_rd;
				cmd.rd_addr = rd_idx_q[IDX_W-1:0];
				cmd.wr_en   = vld_s1 && !sts.pt_dom_ent;
				cmd.wr_addr = kept_q[IDX_W-1:0];
			end
			ST_APPEND: begin
				cmd.wr_en        = !dom_q && room;
				cmd.wr_sel_point = 1'b1;
				cmd.wr_addr      = kept_q[IDX_W-1:0];
			end
			ST_DUMP_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = rd_idx_q[IDX_W-1:0];
			end
			ST_DUMP_LD: begin
				cmd.load_out = 1'b1;
				cmd.out_last = is_last;
				cmd.out_ovf  = ovf_q;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			kept_q      <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			dom_q       <= 1'b0;
			vld_s1      <= 1'b0;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						final_q  <= in_final;
						rd_idx_q <= '0;
						kept_q   <= '0;
						dom_q    <= 1'b0;
						vld_s1   <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					vld_s1 <= scan_rd;
					if (scan_rd) begin
						rd_idx_q <= rd_idx_q + CNT_ONE;
					end
					if (vld_s1) begin
						if (sts.ent_dom_pt) begin
							dom_q <= 1'b1;
						end
						if (!sts.pt_dom_ent) begin
							kept_q <= kept_q + CNT_ONE;
						end
					end
					if (!scan_rd && !vld_s1) begin
						state_q <= ST_APPEND;
					end
				end
				ST_APPEND: begin
					if (!dom_q && room) begin
						count_q <= kept_q + CNT_ONE;
					end else begin
						count_q <= kept_q;
					end
					if (!dom_q && !room) begin
						ovf_q <= 1'b1;
					end
					rd_idx_q <= '0;
					state_q  <= final_q ? ST_DUMP_RD : ST_IDLE;
				end
				ST_DUMP_RD: begin
					state_q <= ST_DUMP_LD;
				end
				ST_DUMP_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_DUMP_WAIT;
				end
				ST_DUMP_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (is_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q + CNT_ONE;
							state_q  <= ST_DUMP_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/pareto_archive_filter_2d.sv */
// top level of the 2-d pareto archive filter: controller plus datapath
// depends on paf2d_pkg, paf2d_pt_if, paf2d_res_if, paf2d_ctrl, paf2d_datapath
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | beat contents
// ---------+-----+-----------------------------------------------------------
// pts      | in  | obj_first, obj_second, tag, final_point: one point per beat
// front    | out | out_first, out_second, out_tag, overflowed, last_entry
//
// one point is accepted, then scanned over the single-read-port archive memory,
// one entry per cycle, then appended; a final point then dumps the archive one
// entry at a time (read, load, hold until ready), so downstream stall slows it
// reset clears the entry count and overflow flag; memory contents need no reset
// no new point is taken until the dump of a final point has fully drained
// front holds its beat in a register until ready; pts waits while busy

module pareto_archive_filter_2d import paf2d_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	paf2d_pt_if.sink   pts,
	paf2d_res_if.source front
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	entry_t  res_entry;

	// sequencing: scan and compaction, append or overflow, dump and clear
	paf2d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pts.valid),
		.in_ready  (pts.ready),
		.in_final  (pts.final_point),
		.out_valid (front.valid),
		.out_ready (front.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// archive storage, compare against the held point, dump register
	paf2d_datapath u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.sts       (sts),
		.pt_first  (pts.obj_first),
		.pt_second (pts.obj_second),
		.pt_tag    (pts.tag),
		.res_entry (res_entry),
		.res_ovf   (front.overflowed),
		.res_last  (front.last_entry)
	);

	assign front.out_first  = res_entry.first;
	assign front.out_second = res_entry.second;
	assign front.out_tag    = res_entry.tag;

endmodule

`default_nettype wire
